FILE: rtl/tfm_pkg.sv
// ----------------------------------------------------------------------------
// tfm_pkg: shared types and constants of the trapezoid membership unit
// Command and corner codes, result format and divider step count.
// ----------------------------------------------------------------------------
`default_nettype none

package tfm_pkg;

    // Command carried by each input word
    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    // Corner points of one trapezoid, in table order
    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2,
        CORNER_D = 2'd3
    } t_corner;

    // Membership is unsigned Q1.15
    localparam int MEMB_W = 16;
    localparam logic [MEMB_W-1:0] FULL_SCALE = 16'h8000;

    // One quotient bit per divider step: the integer bit and 15 fraction bits
    localparam int QUOT_STEPS = MEMB_W;
    localparam int STEP_W     = $clog2(QUOT_STEPS);

endpackage

`default_nettype wire

FILE: rtl/tfm_in_if.sv
// ----------------------------------------------------------------------------
// tfm_in_if: command channel of the trapezoid membership unit
// Valid/ready channel carrying a load or evaluate word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfm_in_if
    import tfm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    t_cmd                          command;
    logic [2:0]                    partition_index;
    logic [1:0]                    corner_index;
    logic signed [SAMPLE_BITS-1:0] value;

    modport source (
        output valid, command, partition_index, corner_index, value,
        input  ready
    );

    modport sink (
        input  valid, command, partition_index, corner_index, value,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tfm_out_if.sv
// ----------------------------------------------------------------------------
// tfm_out_if: result channel of the trapezoid membership unit
// Valid/ready channel carrying one Q1.15 membership word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfm_out_if
    import tfm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MEMB_W-1:0] membership;

    modport source (
        output valid, membership,
        input  ready
    );

    modport sink (
        input  valid, membership,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tfm_ram.sv
// ----------------------------------------------------------------------------
// tfm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: rtl/trapezoid_fuzzy_membership_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_fuzzy_membership_unit: trapezoidal fuzzy membership evaluator
// Corner table in RAM, bit-serial restoring divider for the slope quotient.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one word per command. A load word writes corner a, b, c or
//   d of a partition into the corner table and yields no result; loads to a
//   partition at or past PARTITIONS are dropped. An evaluate word gives a
//   partition and a signed sample x and yields one membership word on o_rsp,
//   unsigned Q1.15, where 16'h8000 means 1.0.
//   A load writes the table when it is accepted. An evaluate reads the four
//   corners from the single RAM read port, picks the segment and, on a sloped
//   segment, runs the restoring divider one quotient bit per cycle before
//   raising o_rsp.valid. Outside the trapezoid or on the plateau the divider
//   is skipped; a partition out of range skips the corner reads too and
//   yields zero. No new word is accepted until an evaluate has left the done
//   state.
//   The output register holds the last result until taken, and new words are
//   accepted meanwhile; a finished evaluate waits only if that register is
//   still full. Reset clears the control state and the output valid; the
//   corner table is not cleared, and each corner must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_fuzzy_membership_unit
    import tfm_pkg::*;
#(
    parameter int PARTITIONS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tfm_in_if.sink     i_req,
    tfm_out_if.source  o_rsp
);
    localparam int SB     = SAMPLE_BITS;
    localparam int DEPTH  = PARTITIONS * 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [2:0]            r_part;
    t_corner               r_cap;
    logic signed [SB-1:0]  r_x;
    logic signed [SB-1:0]  r_a;
    logic signed [SB-1:0]  r_c;
    logic                  r_lt_a;
    logic                  r_lt_b;
    logic                  r_lt_c;
    logic                  r_ge_d;
    logic [SB-1:0]         r_num_rise;
    logic [SB-1:0]         r_den_rise;
    logic [SB-1:0]         r_num_fall;
    logic [SB-1:0]         r_den_fall;
    logic [SB-1:0]         r_den;
    logic [SB:0]           r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [MEMB_W-1:0]     r_quot;
    logic [MEMB_W-1:0]     r_memb;
    logic                  r_out_valid;

    logic                  in_acc;
    logic                  in_ok;
    logic                  ram_we;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [SB-1:0]         rd_data;
    logic signed [SB-1:0]  rd_s;
    logic signed [SB:0]    n_x_minus_rd;
    logic signed [SB:0]    n_rd_minus_x;
    logic signed [SB:0]    n_rd_minus_prev;
    logic [SB+1:0]         n_trial;
    logic                  n_bit;
    logic [SB:0]           n_keep;

    // Table address of one corner of one partition
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [2:0] part,
                                                   input t_corner    cr);
        logic [ADDR_W+4:0] wide;
        wide = {{ADDR_W{1'b0}}, part, cr};
        return wide[ADDR_W-1:0];
    endfunction

    // Sign-extended difference of two samples
    function automatic logic signed [SB:0] sub_ext(input logic signed [SB-1:0] x,
                                                   input logic signed [SB-1:0] y);
        return {x[SB-1], x} - {y[SB-1], y};
    endfunction

    // Input handshake and table write
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_ok       = int'(i_req.partition_index) < PARTITIONS;
    assign ram_we      = in_acc && (i_req.command == CMD_LOAD) && in_ok;
    assign waddr       = tbl_addr(i_req.partition_index, t_corner'(i_req.corner_index));

    // Read corner a at accept, then b, c, d while capturing the previous one
    assign raddr = (r_state == S_IDLE) ? tbl_addr(i_req.partition_index, CORNER_A)
                                       : tbl_addr(r_part, t_corner'(r_cap + 2'd1));

    tfm_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_req.value),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Compare the sample against the arriving corner, form slope terms
    assign rd_s            = $signed(rd_data);
    assign n_x_minus_rd    = sub_ext(r_x, rd_s);
    assign n_rd_minus_x    = sub_ext(rd_s, r_x);
    assign n_rd_minus_prev = sub_ext(rd_s, (r_cap == CORNER_B) ? r_a : r_c);

    // One restoring division step
    assign n_trial = {1'b0, r_rem} - {2'b00, r_den};
    assign n_bit   = !n_trial[SB+1];
    assign n_keep  = n_bit ? n_trial[SB:0] : r_rem;

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CORNER_A;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken word unless the done state refills the register
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req.command == CMD_EVAL)) begin
                        r_part <= i_req.partition_index;
                        r_x    <= i_req.value;
                        r_cap  <= CORNER_A;
                        if (in_ok) begin
                            r_state <= S_READ;
                        end else begin
                            r_quot  <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_READ: begin
                    r_cap <= t_corner'(r_cap + 2'd1);
                    case (r_cap)
                        CORNER_A: begin
                            r_a        <= rd_s;
                            r_lt_a     <= n_x_minus_rd[SB];
                            r_num_rise <= n_x_minus_rd[SB-1:0];
                        end
                        CORNER_B: begin
                            r_lt_b     <= n_x_minus_rd[SB];
                            r_den_rise <= n_rd_minus_prev[SB-1:0];
                        end
                        CORNER_C: begin
                            r_c    <= rd_s;
                            r_lt_c <= n_x_minus_rd[SB];
                        end
                        CORNER_D: begin
                            r_ge_d     <= !n_x_minus_rd[SB];
                            r_num_fall <= n_rd_minus_x[SB-1:0];
                            r_den_fall <= n_rd_minus_prev[SB-1:0];
                            r_state    <= S_SEL;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_SEL: begin
                    r_step <= '0;
                    if (r_lt_a || r_ge_d) begin
                        r_quot  <= '0;
                        r_state <= S_DONE;
                    end else if (r_lt_b) begin
                        r_quot  <= '0;
                        r_rem   <= {1'b0, r_num_rise};
                        r_den   <= r_den_rise;
                        r_state <= S_DIV;
                    end else if (r_lt_c) begin
                        r_quot  <= FULL_SCALE;
                        r_state <= S_DONE;
                    end else begin
                        r_quot  <= '0;
                        r_rem   <= {1'b0, r_num_fall};
                        r_den   <= r_den_fall;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_quot <= {r_quot[MEMB_W-2:0], n_bit};
                    r_rem  <= {n_keep[SB-1:0], 1'b0};
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_memb      <= r_quot;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.membership = r_memb;

    // A new result word only ever comes out of the done state
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result word raised outside the done state");

    // Membership never exceeds 1.0
    a_memb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_memb <= FULL_SCALE)
        else $error("membership above full scale");

    // Divider remainder stays below twice the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < {1'b0, r_den, 1'b0}))
        else $error("divider remainder out of bound");

    // A finished result waits while the output register is still full
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> r_state == S_DONE)
        else $error("result overwrote a pending word");

    // A load finishes in its accept cycle
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.command == CMD_LOAD) |=> r_state == S_IDLE)
        else $error("load did not return to idle");
endmodule

`default_nettype wire

FILE: tb/trapezoid_fuzzy_membership_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_fuzzy_membership_unit_tb: self-checking bench of the membership unit
// Loads trapezoid corners and evaluates samples through the request channel.
// Each evaluate word is scored against a local corner table and the Q1.15
// slope formula, and compared in order with the words on the result channel.
// Both sides stall at random in the first two of three phases; in the last the receiver holds off once.
// ----------------------------------------------------------------------------

module trapezoid_fuzzy_membership_unit_tb
    import tfm_pkg::*;
;

    localparam int NUM_PARTS       = 8;
    localparam int SAMPLE_W        = 16;
    localparam int WORDS_PER_PHASE = 467;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        t_cmd                       cmd;
        logic [2:0]                 part;
        t_corner                    corner;
        logic signed [SAMPLE_W-1:0] value;
    } req_word_t;

    logic i_clk;
    logic i_rst_n;

    tfm_in_if #(.SAMPLE_BITS(SAMPLE_W)) req_if ();
    tfm_out_if                          rsp_if ();

    trapezoid_fuzzy_membership_unit #(
        .PARTITIONS  (NUM_PARTS),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    req_word_t                  pending_words[$];
    logic [MEMB_W-1:0]          expected_memb[$];
    logic signed [SAMPLE_W-1:0] corner_mem [0:NUM_PARTS-1][0:3];
    logic [3:0]                 loaded_gen [0:NUM_PARTS-1];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_ask      = 0;
    int   hold_done     = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    int   words_made    = 0;
    logic req_taken     = 1'b0;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Trapezoid membership of sample x in one partition, Q1.15 truncated
    function automatic logic [MEMB_W-1:0] membership_of(
        input logic [2:0]                 part,
        input logic signed [SAMPLE_W-1:0] x
    );
        longint a, b, c, d, xv, q;
        if (part >= NUM_PARTS) return '0;
        a  = corner_mem[part][CORNER_A];
        b  = corner_mem[part][CORNER_B];
        c  = corner_mem[part][CORNER_C];
        d  = corner_mem[part][CORNER_D];
        xv = x;
        if (xv < a || xv >= d)
            q = 0;
        else if (xv < b)
            q = ((xv - a) * 32768) / (b - a);
        else if (xv < c)
            q = FULL_SCALE;
        else
            q = ((d - xv) * 32768) / (d - c);
        return q[MEMB_W-1:0];
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    task automatic push_load(input int part, input int corner, input int v);
        req_word_t w;
        w.cmd    = CMD_LOAD;
        w.part   = part[2:0];
        w.corner = t_corner'(corner);
        w.value  = v[SAMPLE_W-1:0];
        pending_words.push_back(w);
        loaded_gen[part][corner] = 1'b1;
        words_made++;
    endtask

    // Corner field is don't-care on evaluate: fill it with noise
    task automatic push_eval(input int part, input int x);
        req_word_t w;
        w.cmd    = CMD_EVAL;
        w.part   = part[2:0];
        w.corner = t_corner'($urandom_range(3));
        w.value  = x[SAMPLE_W-1:0];
        pending_words.push_back(w);
        words_made++;
    endtask

    // Pick a partition whose four corners are all written
    function automatic int pick_loaded();
        int p;
        p = $urandom_range(NUM_PARTS - 1);
        while (loaded_gen[p] != 4'hf) p = (p + 1) % NUM_PARTS;
        return p;
    endfunction

    // One sorted trapezoid followed by samples, most of them clustered around it
    task automatic add_trapezoid_group();
        int p, lo, span, k, t, n, r, x;
        int v [0:3];
        p = $urandom_range(NUM_PARTS - 1);
        case ($urandom_range(3))
            0: begin
                span = $urandom_range(1, 16);
            end
            1: begin
                span = $urandom_range(17, 1024);
            end
            2: begin
                span = $urandom_range(1025, 65535);
            end
            default: begin
                span = 65535;
            end
        endcase
        lo = -32768 + $urandom_range(0, 65535 - span);
        for (int i = 0; i < 4; i++) v[i] = lo + $urandom_range(0, span);
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3 - j; i++) begin
                if (v[i] > v[i+1]) begin
                    t = v[i]; v[i] = v[i+1]; v[i+1] = t;
                end
            end
        end
        // Collapse the plateau now and then
        if ($urandom_range(7) == 0) v[2] = v[1];
        r = $urandom_range(1);
        for (int i = 0; i < 4; i++) begin
            k = r ? 3 - i : i;
            push_load(p, k, v[k]);
        end
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(9);
            if (r == 0)
                x = $urandom_range(0, 65535) - 32768;
            else if (r == 1)
                x = v[$urandom_range(3)];
            else
                x = v[0] - 2 + $urandom_range(0, v[3] - v[0] + 4);
            if ($urandom_range(5) == 0)
                push_eval(pick_loaded(), clamp_sample(x));
            else
                push_eval(p, clamp_sample(x));
        end
    endtask

    // Stray load or stray evaluate
    task automatic add_noise_word();
        if ($urandom_range(1))
            push_load($urandom_range(NUM_PARTS - 1), $urandom_range(3),
                      $urandom_range(0, 65535) - 32768);
        else
            push_eval(pick_loaded(), $urandom_range(0, 65535) - 32768);
    endtask

    // Hold the sender until every queued word is taken and every result is in
    task automatic wait_drained();
        while (pending_words.size() != 0 || req_if.valid || expected_memb.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic [MEMB_W-1:0] want,
                                 input logic [MEMB_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected membership %0d, got %0d", $realtime, what,
                     want, got);
    endtask

    // Request driver: advance on acceptance, idle at random between words
    always @(negedge i_clk) begin : driver_p
        req_word_t w;
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                req_if.valid           <= 1'b1;
                req_if.command         <= w.cmd;
                req_if.partition_index <= w.part;
                req_if.corner_index    <= w.corner;
                req_if.value           <= w.value;
            end else begin
                req_if.valid <= 1'b0;
                req_if.value <= SAMPLE_W'($urandom);
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin : receiver_p
        if (hold_done != hold_ask) begin
            hold_done = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: score results first, then update the corner table and predict
    always @(posedge i_clk) begin : monitor_p
        logic [MEMB_W-1:0] want;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_memb.size() == 0) begin
                note_mismatch("unexpected result word", '0, rsp_if.membership);
            end else begin
                want = expected_memb.pop_front();
                if (rsp_if.membership !== want)
                    note_mismatch("membership mismatch", want, rsp_if.membership);
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            if (req_if.command == CMD_LOAD) begin
                if (req_if.partition_index < NUM_PARTS)
                    corner_mem[req_if.partition_index][req_if.corner_index] = req_if.value;
            end else begin
                expected_memb.push_back(membership_of(req_if.partition_index,
                                                      req_if.value));
            end
        end
    end

    // Watchdog: drop the run when neither channel moves for too long
    always @(posedge i_clk) begin : watchdog_p
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n                = 1'b0;
        req_if.valid           = 1'b0;
        req_if.command         = CMD_LOAD;
        req_if.partition_index = '0;
        req_if.corner_index    = CORNER_A;
        req_if.value           = '0;
        rsp_if.ready           = 1'b0;
        for (int i = 0; i < NUM_PARTS; i++) loaded_gen[i] = 4'h0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full-range rising and falling edges with an empty plateau
        push_load(0, CORNER_A, -32768);
        push_load(0, CORNER_B, 0);
        push_load(0, CORNER_C, 0);
        push_load(0, CORNER_D, 32767);
        push_eval(0, -32768);
        push_eval(0, -1);
        push_eval(0, 0);
        push_eval(0, 32766);
        push_eval(0, 32767);
        // Symmetric trapezoid: outside, both slopes, plateau, right edge
        push_load(1, CORNER_A, -100);
        push_load(1, CORNER_B, -50);
        push_load(1, CORNER_C, 50);
        push_load(1, CORNER_D, 100);
        push_eval(1, -101);
        push_eval(1, -75);
        push_eval(1, 0);
        push_eval(1, 99);
        push_eval(1, 100);
        // Degenerate trapezoid, all corners equal, loaded back to front
        push_load(7, CORNER_D, 7);
        push_load(7, CORNER_C, 7);
        push_load(7, CORNER_B, 7);
        push_load(7, CORNER_A, 7);
        push_eval(7, 7);
        // Corners out of order
        push_load(2, CORNER_A, -5);
        push_load(2, CORNER_B, 30);
        push_load(2, CORNER_C, 10);
        push_load(2, CORNER_D, 40);
        push_eval(2, 20);
        push_eval(2, 35);
        wait_drained();

        // Random phases: receiver-idle, sender-idle, then one long receiver hold-off and no random idling
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_ask++;
                end
            endcase
            words_made = 0;
            while (words_made < WORDS_PER_PHASE) begin
                if ($urandom_range(9) == 0)
                    add_noise_word();
                else
                    add_trapezoid_group();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_memb.size() != 0) begin
            $display("%0d expected results never arrived", expected_memb.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
